// ===== sv/tbsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsr_pkg
// Shared types and constants of the track buffered sector reader.
// ----------------------------------------------------------------------------
package tbsr_pkg;

   localparam int SEC_W    = 24;
   localparam int SPT_W    = 6;
   localparam int HEADS_W  = 8;
   localparam int START_W  = 25;
   localparam int STATUS_W = 8;
   localparam int RETRY_W  = 3;

   localparam int DEF_MAX_TRACK_SECTORS = 21;
   localparam int DEF_RETRY_LIMIT       = 5;

   localparam logic [SPT_W-1:0] SPT_RESET = 6'd7;

   // configuration register indexes
   localparam logic [1:0] REG_SPT   = 2'd0;
   localparam logic [1:0] REG_HEADS = 2'd1;
   localparam logic [1:0] REG_DRIVE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_OK    = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // request from control to the divider and back
   typedef struct packed {
      logic             start;
      logic [SEC_W-1:0] dividend;
      logic [HEADS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SEC_W-1:0] quotient;
      logic [HEADS_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== sv/tbsr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsr_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbsr_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  tbsr_pkg::div_req_type div_req,
   output tbsr_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(tbsr_pkg::SEC_W + 1);

   logic [tbsr_pkg::SEC_W-1:0]   quot_ff, quot_in;
   logic [tbsr_pkg::HEADS_W:0]   rem_ff, rem_in;
   logic [tbsr_pkg::HEADS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [tbsr_pkg::HEADS_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[tbsr_pkg::HEADS_W-1:0], quot_ff[tbsr_pkg::SEC_W-1]};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(tbsr_pkg::SEC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[tbsr_pkg::SEC_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[tbsr_pkg::SEC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff[tbsr_pkg::HEADS_W-1:0];

   no_done_while_busy : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff) else $error("divider done while busy");
   done_after_last : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1) && !div_req.start) |=> done_ff)
      else $error("divider missed done");
   rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (done_ff && dvs_ff != '0) |-> rem_ff < {1'b0, dvs_ff})
      else $error("remainder out of range");

endmodule

// ===== sv/track_buffered_sector_reader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_buffered_sector_reader_top
// Logical sector to cylinder/head/sector reader with a one-track cache.
//
// req_ carries sector requests (tuser = 0) and read completions (tuser = 1).
// rsp_ gives read commands, success replies and error replies, at most one
// per request. csr_ writes sectors_per_track (0), head_count (1) and
// drive_number (2); write it only while idle.
// A sector request with a geometry runs two bit-serial divisions on one
// shared divider (ST_DIV1, ST_DIV2) and then ST_DEC registers its result;
// the next request is taken after the result leaves and ST_OUT returns to
// ST_IDLE. In linear addressing the divisions are skipped and ST_DEC
// registers the result. A completion's result is registered at its accept
// edge; the next request can follow once it leaves. One request at a time.
// The result sits in an output register; a stalled receiver holds it and
// req_tready stays low until it is taken.
// Reset clears the cache, the bad-track mark and the registers to
// sectors_per_track 7, head_count 0, drive_number 0.
// ----------------------------------------------------------------------------
module track_buffered_sector_reader_top #(
   parameter int MAX_TRACK_SECTORS = tbsr_pkg::DEF_MAX_TRACK_SECTORS,
   parameter int RETRY_LIMIT       = tbsr_pkg::DEF_RETRY_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sector_number[23:0], read_status[31:24]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // cylinder, head, start_sector,
                                    // sector_count, buffer_offset, error_status
   output logic [1:0]  rsp_tuser,   // kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV1  = 5'b00010,
      ST_DIV2  = 5'b00100,
      ST_DEC   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   localparam int SW = tbsr_pkg::SEC_W;
   localparam int HW = tbsr_pkg::HEADS_W;

   state_type state_ff, state_in;
   logic [tbsr_pkg::SPT_W-1:0]   spt_ff, spt_in;
   logic [HW-1:0]                heads_ff, heads_in;
   logic [7:0]                   drive_ff, drive_in;
   logic [1:0]                   phase_ff, phase_in; // 0 idle,1 track,2 single
   logic [SW-1:0]                ctrack_ff, ctrack_in, btrack_ff, btrack_in;
   logic                         cvalid_ff, cvalid_in, bvalid_ff, bvalid_in;
   logic [tbsr_pkg::RETRY_W-1:0] retry_ff, retry_in;
   logic [SW-1:0]                pcyl_ff, pcyl_in, ptrack_ff, ptrack_in;
   logic [HW-1:0]                phead_ff, phead_in;
   logic [tbsr_pkg::START_W-1:0] psec_ff, psec_in;
   logic [SW-1:0]                sec_ff, sec_in;
   logic                         ov_ff, ov_in;
   logic [79:0]                  od_ff, od_in;
   logic [1:0]                   ok_ff, ok_in;
   tbsr_pkg::div_req_type        div_req;
   tbsr_pkg::div_rsp_type        div_rsp;
   logic                         req_fire, linear, cacheable;
   logic [7:0]                   status;

   tbsr_divider u_div (.clock(clock), .reset(reset), .div_req(div_req),
                       .div_rsp(div_rsp));

   assign req_tready = (state_ff == ST_IDLE) && !ov_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign status     = req_tdata[31:24];
   assign linear     = (spt_ff == '0) || (heads_ff == '0);
   assign cacheable  = (heads_ff != '0) && (spt_ff > 6'd1) &&
                       ({2'b0, spt_ff} <= 8'(MAX_TRACK_SECTORS));
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ok_ff;

   function automatic logic [79:0] pack(input logic [SW-1:0] c,
      input logic [HW-1:0] h, input logic [24:0] s, input logic [5:0] n,
      input logic [5:0] o, input logic [7:0] e);
      pack = {3'b0, e, o, n, s, h, c};
   endfunction

   always_comb begin
      state_in  = state_ff;
      spt_in    = spt_ff;
      heads_in  = heads_ff;
      drive_in  = drive_ff;
      phase_in  = phase_ff;
      ctrack_in = ctrack_ff;
      cvalid_in = cvalid_ff;
      btrack_in = btrack_ff;
      bvalid_in = bvalid_ff;
      retry_in  = retry_ff;
      pcyl_in   = pcyl_ff;
      phead_in  = phead_ff;
      psec_in   = psec_ff;
      ptrack_in = ptrack_ff;
      sec_in    = sec_ff;
      ov_in     = ov_ff && !rsp_tready;
      od_in     = od_ff;
      ok_in     = ok_ff;
      div_req   = '{start: 1'b0, dividend: sec_ff, divisor: {2'b0, spt_ff}};

      if (csr_valid) begin
         unique case (csr_index)
            tbsr_pkg::REG_SPT: begin
               spt_in    = csr_data[5:0];
               cvalid_in = 1'b0;
            end
            tbsr_pkg::REG_HEADS: heads_in = csr_data;
            tbsr_pkg::REG_DRIVE: drive_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_tuser) begin
                  if (phase_ff == 2'd0) begin
                     sec_in = req_tdata[SW-1:0];
                     if (linear) begin
                        pcyl_in   = '0;
                        phead_in  = '0;
                        ptrack_in = '0;
                        psec_in   = {1'b0, req_tdata[SW-1:0]} + 25'd1;
                        state_in  = ST_DEC;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req_tdata[SW-1:0];
                        state_in         = ST_DIV1;
                     end
                  end
               end else if (phase_ff == 2'd1) begin
                  if (status == '0) begin
                     ctrack_in = ptrack_ff;
                     cvalid_in = 1'b1;
                     phase_in  = 2'd0;
                     ok_in = tbsr_pkg::KIND_OK;
                     od_in = pack('0, '0, '0, '0, psec_ff[5:0] - 6'd1, '0);
                  end else begin
                     btrack_in = ptrack_ff;
                     bvalid_in = 1'b1;
                     cvalid_in = 1'b0;
                     retry_in  = tbsr_pkg::RETRY_W'(RETRY_LIMIT - 1);
                     phase_in  = 2'd2;
                     ok_in = tbsr_pkg::KIND_READ;
                     od_in = pack(pcyl_ff, phead_ff, psec_ff, 6'd1, '0, '0);
                  end
                  ov_in = 1'b1;
               end else if (phase_ff == 2'd2) begin
                  if (status == '0) begin
                     phase_in = 2'd0;
                     ok_in = tbsr_pkg::KIND_OK;
                     od_in = '0;
                  end else if (retry_ff != '0) begin
                     retry_in = retry_ff - 1'b1;
                     ok_in = tbsr_pkg::KIND_READ;
                     od_in = pack(pcyl_ff, phead_ff, psec_ff, 6'd1, '0, '0);
                  end else begin
                     phase_in = 2'd0;
                     ok_in = tbsr_pkg::KIND_ERROR;
                     od_in = pack('0, '0, '0, '0, '0, status);
                  end
                  ov_in = 1'b1;
               end
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               // track = sec / spt, sector = remainder + 1
               ptrack_in        = div_rsp.quotient;
               psec_in          = {17'b0, div_rsp.remainder} + 25'd1;
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = heads_ff;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               pcyl_in  = div_rsp.quotient;
               phead_in = div_rsp.remainder;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (cacheable && cvalid_ff && ctrack_ff == ptrack_ff) begin
               ok_in = tbsr_pkg::KIND_OK;
               od_in = pack('0, '0, '0, '0, psec_ff[5:0] - 6'd1, '0);
            end else if (cacheable && !(bvalid_ff && btrack_ff == ptrack_ff)) begin
               phase_in = 2'd1;
               ok_in = tbsr_pkg::KIND_READ;
               od_in = pack(pcyl_ff, phead_ff, 25'd1, spt_ff, '0, '0);
            end else begin
               cvalid_in = 1'b0;
               retry_in  = tbsr_pkg::RETRY_W'(RETRY_LIMIT - 1);
               phase_in  = 2'd2;
               ok_in = tbsr_pkg::KIND_READ;
               od_in = pack(pcyl_ff, phead_ff, psec_ff, 6'd1, '0, '0);
            end
            ov_in    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pcyl_ff   <= pcyl_in;
      phead_ff  <= phead_in;
      psec_ff   <= psec_in;
      ptrack_ff <= ptrack_in;
      sec_ff    <= sec_in;
      od_ff     <= od_in;
      ok_ff     <= ok_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         spt_ff    <= tbsr_pkg::SPT_RESET;
         heads_ff  <= '0;
         drive_ff  <= '0;
         phase_ff  <= 2'd0;
         ctrack_ff <= '0;
         cvalid_ff <= 1'b0;
         btrack_ff <= '0;
         bvalid_ff <= 1'b0;
         retry_ff  <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         spt_ff    <= spt_in;
         heads_ff  <= heads_in;
         drive_ff  <= (drive_in == drive_ff) ? drive_ff : drive_in;
         phase_ff  <= phase_in;
         ctrack_ff <= ctrack_in;
         cvalid_ff <= cvalid_in;
         btrack_ff <= btrack_in;
         bvalid_ff <= bvalid_in;
         retry_ff  <= retry_in;
         ov_ff     <= ov_in;
      end
   end

   no_accept_while_full : assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !req_tready) else $error("request accepted over pending result");
   dec_gives_result : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEC |=> ov_ff) else $error("no result after decode");
   phase_legal : assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("bad phase");

endmodule
